// ----- rtl/dual_notch_cascade_mix_unit_defines.svh -----
// Assertion macros for the notch cascade mix unit.
`ifndef DUAL_NOTCH_CASCADE_MIX_UNIT_DEFINES_SVH
`define DUAL_NOTCH_CASCADE_MIX_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define DNCM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dncm assertion failed");

// Next-cycle implication, checked on clk_i, off during reset.
`define DNCM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dncm assertion failed");

`endif

// ----- rtl/dncm_pkg.sv -----
// Types, constants, microcode program and helpers of the notch cascade mix unit.
`default_nettype none

package dncm_pkg;

  localparam int unsigned DEF_STAGES   = 2;
  localparam int unsigned DEF_CHANNELS = 2;

  localparam int unsigned SMP_W     = 24;  // audio sample
  localparam int unsigned CFG_W     = 32;  // config write data
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COEF_W    = 32;  // Q4.28 coefficient
  localparam int unsigned SIG_W     = 32;  // stage signal, 4 bits below sample lsb
  localparam int unsigned DRY_W     = 28;
  localparam int unsigned DRY_SHIFT = 4;
  localparam int unsigned ST_W      = 40;  // delay state
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned RND_SHIFT = 28;
  localparam int unsigned RND_W     = PROD_W - RND_SHIFT;
  localparam int unsigned ACC_W     = 50;
  localparam int unsigned MIX_W     = 17;
  localparam int unsigned FULL_MIX  = 65536;
  localparam int unsigned MIX_SHIFT = 20;
  localparam int unsigned MIXQ_SHIFT = 16;
  localparam int unsigned PC_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_EDGE   = 3'd0,
    REG_LOW_MID    = 3'd1,
    REG_LOW_POLE   = 3'd2,
    REG_HIGH_EDGE  = 3'd3,
    REG_HIGH_MID   = 3'd4,
    REG_HIGH_POLE  = 3'd5,
    REG_WET        = 3'd6
  } cfg_reg_e;

  // microcode fields
  typedef enum logic [1:0] {
    CS_B0    = 2'd0,
    CS_B1    = 2'd1,
    CS_A2    = 2'd2,
    CS_DEPTH = 2'd3
  } csel_e;

  typedef enum logic [1:0] {
    SS_X   = 2'd0,
    SS_Y   = 2'd1,
    SS_DRY = 2'd2
  } ssel_e;

  typedef enum logic [2:0] {
    ACC_NOP      = 3'd0,
    ACC_RND_S2   = 3'd1,
    ACC_SUB_RND  = 3'd2,
    ACC_DRY_PROD = 3'd3,
    ACC_SUB_PROD = 3'd4
  } acc_op_e;

  typedef enum logic [2:0] {
    J_NEXT = 3'd0,  // fall through
    J_GOTO = 3'd1,
    J_WAIT = 3'd2,  // hold until a word arrives, branch on bypass
    J_LOOP = 3'd3,  // branch while stages remain
    J_HOLD = 3'd4   // hold while output busy, else branch
  } jmp_e;

  typedef struct packed {
    logic            accept;
    logic            mem_rd;
    logic            ld_y;
    logic            mem_wr;
    logic            ld_out;
    acc_op_e         acc_op;
    csel_e           csel;
    ssel_e           ssel;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic bypass;
    logic more;
    logic out_busy;
  } cond_t;

  localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
  localparam logic [PC_W-1:0] PC_RD   = 4'd1;
  localparam logic [PC_W-1:0] PC_Y    = 4'd2;
  localparam logic [PC_W-1:0] PC_S1A  = 4'd3;
  localparam logic [PC_W-1:0] PC_S1B  = 4'd4;
  localparam logic [PC_W-1:0] PC_WR   = 4'd5;
  localparam logic [PC_W-1:0] PC_MIXA = 4'd6;
  localparam logic [PC_W-1:0] PC_MIXB = 4'd7;
  localparam logic [PC_W-1:0] PC_MIXC = 4'd8;
  localparam logic [PC_W-1:0] PC_OUT  = 4'd9;

  // control store
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    unique case (pc)
      PC_WAIT: begin
        w.accept = 1'b1;
        w.jmp    = J_WAIT;
        w.target = PC_OUT;
      end
      PC_RD: begin
        w.mem_rd = 1'b1;
        w.csel   = CS_B0;
        w.ssel   = SS_X;
      end
      PC_Y: begin
        w.ld_y = 1'b1;
        w.csel = CS_B1;
        w.ssel = SS_X;
      end
      PC_S1A: begin
        w.acc_op = ACC_RND_S2;
        w.csel   = CS_B1;
        w.ssel   = SS_Y;
      end
      PC_S1B: begin
        w.acc_op = ACC_SUB_RND;
        w.csel   = CS_A2;
        w.ssel   = SS_Y;
      end
      PC_WR: begin
        w.mem_wr = 1'b1;
        w.jmp    = J_LOOP;
        w.target = PC_RD;
      end
      PC_MIXA: begin
        w.csel = CS_DEPTH;
        w.ssel = SS_X;
      end
      PC_MIXB: begin
        w.acc_op = ACC_DRY_PROD;
        w.csel   = CS_DEPTH;
        w.ssel   = SS_DRY;
      end
      PC_MIXC: begin
        w.acc_op = ACC_SUB_PROD;
      end
      PC_OUT: begin
        w.ld_out = 1'b1;
        w.jmp    = J_HOLD;
        w.target = PC_WAIT;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

  // (p + 2^27) >>> 28
  function automatic logic signed [RND_W-1:0] rnd_q28(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) << (RND_SHIFT - 1));
    return t[PROD_W-1:RND_SHIFT];
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
    logic same;
    same = (v[ACC_W-1:SIG_W-1] == {(ACC_W-SIG_W+1){v[ACC_W-1]}});
    if (same) return v[SIG_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(SIG_W-1){1'b0}}};
    else return {1'b0, {(SIG_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
    logic same;
    same = (v[ACC_W-1:ST_W-1] == {(ACC_W-ST_W+1){v[ACC_W-1]}});
    if (same) return v[ST_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(ST_W-1){1'b0}}};
    else return {1'b0, {(ST_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SMP_W-1:0] sat_smp(
    input logic signed [ACC_W-MIX_SHIFT-1:0] v
  );
    logic same;
    same = (v[ACC_W-MIX_SHIFT-1:SMP_W-1] == {(ACC_W-MIX_SHIFT-SMP_W+1){v[ACC_W-MIX_SHIFT-1]}});
    if (same) return v[SMP_W-1:0];
    else if (v[ACC_W-MIX_SHIFT-1]) return {1'b1, {(SMP_W-1){1'b0}}};
    else return {1'b0, {(SMP_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dncm_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jumps.
`default_nettype none

module dncm_seq
  import dncm_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  cond_t cond_i,
  output ctrl_t ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;

  assign ctrl   = ucode_rom(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.jmp)
      J_NEXT: pc_d = pc_q + PC_W'(1);
      J_GOTO: pc_d = ctrl.target;
      J_WAIT: begin
        if (!cond_i.in_fire) pc_d = pc_q;
        else if (cond_i.bypass) pc_d = ctrl.target;
        else pc_d = pc_q + PC_W'(1);
      end
      J_LOOP: pc_d = cond_i.more ? ctrl.target : pc_q + PC_W'(1);
      J_HOLD: pc_d = cond_i.out_busy ? pc_q : ctrl.target;
      default: pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dual_notch_cascade_mix_unit.sv -----
// Top level: notch biquad cascade with dry/wet mix on a shared multiplier.
//
//   channel  direction  handshake              payload
//   in       in         in_valid_i/in_ready_o  sample_in_i, channel_in_i
//   out      out        out_valid_o/out_ready_i sample_out_o, channel_out_o
//   cfg      in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A word takes five steps per biquad on one 32x32 multiplier for each stage of both banks,
// then three mix steps and the load into the result register; the next word is taken
// after that load. A word for an unused channel goes from its accept straight to the load.
// Reset clears the delay state valid bits at once; no clearing pass.
// The result waits in the output register; the sequencer parks at its last step while that
// register is full and out_ready_i is low, and accepts the next word once it loads.
`default_nettype none
`include "dual_notch_cascade_mix_unit_defines.svh"

module dual_notch_cascade_mix_unit
  import dncm_pkg::*;
#(
  parameter int unsigned STAGES_PER_BANK = DEF_STAGES,
  parameter int unsigned CHANNELS        = DEF_CHANNELS
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  signed [SMP_W-1:0]    sample_in_i,
  input  wire                        channel_in_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic signed [SMP_W-1:0]    sample_out_o,
  output logic                       channel_out_o,
  input  wire                        cfg_we_i,
  input  wire         [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire         [CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned NSTAGE = 2 * STAGES_PER_BANK;
  localparam int unsigned DEPTH  = CHANNELS * NSTAGE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STG_W  = $clog2(NSTAGE);

  // configuration
  logic signed [COEF_W-1:0] low_b0_q, low_b1_q, low_a2_q;
  logic signed [COEF_W-1:0] high_b0_q, high_b1_q, high_a2_q;
  logic        [MIX_W-1:0]  wet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_b0_q  <= COEF_W'(1) << RND_SHIFT;
      low_b1_q  <= '0;
      low_a2_q  <= '0;
      high_b0_q <= COEF_W'(1) << RND_SHIFT;
      high_b1_q <= '0;
      high_a2_q <= '0;
      wet_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_EDGE:  low_b0_q  <= cfg_wdata_i;
        REG_LOW_MID:   low_b1_q  <= cfg_wdata_i;
        REG_LOW_POLE:  low_a2_q  <= cfg_wdata_i;
        REG_HIGH_EDGE: high_b0_q <= cfg_wdata_i;
        REG_HIGH_MID:  high_b1_q <= cfg_wdata_i;
        REG_HIGH_POLE: high_a2_q <= cfg_wdata_i;
        REG_WET:       wet_q     <= cfg_wdata_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ctrl_t ctrl;
  cond_t cond;

  dncm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  // datapath registers
  logic signed [SMP_W-1:0]  sample_q;
  logic                     chan_q;
  logic                     bypass_q;
  logic        [STG_W-1:0]  stage_q;
  logic signed [SIG_W-1:0]  x_q, y_q;
  logic signed [RND_W-1:0]  b0x_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     out_busy;

  logic in_fire, bypass_in, more;
  assign in_ready_o = ctrl.accept;
  assign in_fire    = in_valid_i & ctrl.accept;
  assign bypass_in  = !(32'(channel_in_i) < CHANNELS);
  assign more       = (stage_q != STG_W'(NSTAGE - 1));
  assign out_busy   = out_valid_o & ~out_ready_i;

  assign cond = '{in_fire: in_fire, bypass: bypass_in, more: more, out_busy: out_busy};

  // coefficient bank follows the stage index
  logic                     bank_hi;
  logic signed [COEF_W-1:0] b0_c, b1_c, a2_c;
  logic        [MIX_W-1:0]  depth;
  logic signed [DRY_W-1:0]  dry;
  logic signed [COEF_W-1:0] mul_c;
  logic signed [SIG_W-1:0]  mul_s;
  logic signed [RND_W-1:0]  rnd_p;
  logic signed [ACC_W-1:0]  prod_acc;

  assign bank_hi  = (32'(stage_q) >= STAGES_PER_BANK);
  assign b0_c     = bank_hi ? high_b0_q : low_b0_q;
  assign b1_c     = bank_hi ? high_b1_q : low_b1_q;
  assign a2_c     = bank_hi ? high_a2_q : low_a2_q;
  assign depth    = (wet_q > MIX_W'(FULL_MIX)) ? MIX_W'(FULL_MIX) : wet_q;
  assign dry      = {sample_q, {DRY_SHIFT{1'b0}}};
  assign rnd_p    = rnd_q28(prod_q);
  assign prod_acc = prod_q[ACC_W-1:0];

  always_comb begin
    unique case (ctrl.csel)
      CS_B0:    mul_c = b0_c;
      CS_B1:    mul_c = b1_c;
      CS_A2:    mul_c = a2_c;
      CS_DEPTH: mul_c = signed'(COEF_W'(depth));
      default:  mul_c = b0_c;
    endcase
    unique case (ctrl.ssel)
      SS_X:    mul_s = x_q;
      SS_Y:    mul_s = y_q;
      SS_DRY:  mul_s = SIG_W'(dry);
      default: mul_s = x_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_c * mul_s;
  end

  // delay state memories
  logic [ADDR_W-1:0]       addr;
  logic signed [ST_W-1:0]  s1_mem [DEPTH];
  logic signed [ST_W-1:0]  s2_mem [DEPTH];
  logic signed [ST_W-1:0]  s1_rd_q, s2_rd_q;
  logic signed [ST_W-1:0]  s1_eff, s2_eff;
  logic signed [ST_W-1:0]  s1_new, s2_new;
  logic [DEPTH-1:0]        vld_q;
  logic                    rd_vld_q;

  assign addr   = ADDR_W'(32'(chan_q) * NSTAGE + 32'(stage_q));
  assign s1_eff = rd_vld_q ? s1_rd_q : '0;
  assign s2_eff = rd_vld_q ? s2_rd_q : '0;
  assign s1_new = sat_st(acc_q);
  assign s2_new = sat_st(ACC_W'(b0x_q) - ACC_W'(rnd_p));

  always_ff @(posedge clk_i) begin
    if (ctrl.mem_wr) begin
      s1_mem[addr] <= s1_new;
      s2_mem[addr] <= s2_new;
    end
    if (ctrl.mem_rd) begin
      s1_rd_q <= s1_mem[addr];
      s2_rd_q <= s2_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl.mem_wr) vld_q[addr] <= 1'b1;
      if (ctrl.mem_rd) rd_vld_q <= vld_q[addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= '0;
      bypass_q <= 1'b0;
    end else if (in_fire) begin
      stage_q  <= '0;
      bypass_q <= bypass_in;
    end else if (ctrl.mem_wr && more) begin
      stage_q  <= stage_q + STG_W'(1);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_in_i;
      chan_q   <= channel_in_i;
      x_q      <= SIG_W'(signed'({sample_in_i, {DRY_SHIFT{1'b0}}}));
    end else if (ctrl.mem_wr) begin
      x_q      <= y_q;
    end
    if (ctrl.ld_y) begin
      y_q   <= sat_sig(ACC_W'(rnd_p) + ACC_W'(s1_eff));
      b0x_q <= rnd_p;
    end
    unique case (ctrl.acc_op)
      ACC_RND_S2:   acc_q <= ACC_W'(rnd_p) + ACC_W'(s2_eff);
      ACC_SUB_RND:  acc_q <= acc_q - ACC_W'(rnd_p);
      ACC_DRY_PROD: acc_q <= (ACC_W'(dry) <<< MIXQ_SHIFT) + prod_acc;
      ACC_SUB_PROD: acc_q <= acc_q - prod_acc;
      default: ;
    endcase
  end

  // output register
  logic signed [ACC_W-1:0] mix_rnd;
  logic signed [SMP_W-1:0] mix_res;
  logic                    out_ld;

  assign mix_rnd = acc_q + (ACC_W'(1) << (MIX_SHIFT - 1));
  assign mix_res = sat_smp(mix_rnd[ACC_W-1:MIX_SHIFT]);
  assign out_ld  = ctrl.ld_out & ~out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ld) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      sample_out_o  <= bypass_q ? sample_q : mix_res;
      channel_out_o <= chan_q;
    end
  end

  // checks
  `DNCM_ASSERT_NXT(a_accept_leaves_wait, in_valid_i && in_ready_o, !in_ready_o)
  `DNCM_ASSERT_IMP(a_no_state_write_on_bypass, ctrl.mem_wr, !bypass_q)
  `DNCM_ASSERT_IMP(a_stage_in_range, 1'b1, 32'(stage_q) < NSTAGE)
  `DNCM_ASSERT_NXT(a_result_loads, out_ld, out_valid_o)

endmodule

`default_nettype wire
